// File: hdl/gvc_pkg.sv
// shared types and constants for the greedy vertex coloring block
package gvc_pkg;

  localparam int unsigned VERTEX_W = 16;
  localparam int unsigned COLOR_W  = 5;
  localparam int unsigned OQ_DEPTH = 3;
  localparam int unsigned OQ_PW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef logic [VERTEX_W-1:0] vertex_t;

  typedef struct packed {
    logic    valid;
    logic    hit;
    logic    last;
    logic    fwd;
    vertex_t vertex;
  } stage_t;

  typedef struct packed {
    vertex_t              vertex;
    logic [COLOR_W-1:0]   color;
    logic                 overflow;
  } result_t;

endpackage

// File: hdl/greedy_vertex_coloring.sv
// top level: greedy vertex coloring over a streamed neighbor list
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------------
//  in      | in_valid_i / in_ready_o | neighbor_i, neighbor_valid_i, last_i,
//          |                         | first_vertex_i
//  out     | out_valid_o/out_ready_i | vertex_o, color_o, overflow_o
//
// one neighbor transfer per cycle while in_ready_o is high; a result is pushed
// from the registered last transfer (color store read, then mask update and pick)
// a read of the entry written in the same cycle is forwarded from the pick
// reset clears counter, mask and queue; the color store needs no clearing
// in_ready_o drops only while the result queue could not take another result
module greedy_vertex_coloring #(
  parameter int unsigned MAX_VERTICES = 65536,
  parameter int unsigned MAX_COLORS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] neighbor_i,
  input  logic        neighbor_valid_i,
  input  logic        last_i,
  input  logic        first_vertex_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] vertex_o,
  output logic [4:0]  color_o,
  output logic        overflow_o
);

  localparam int unsigned DEPTH = (MAX_VERTICES > 65536) ? 65536 : MAX_VERTICES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_COLORS);

  gvc_pkg::vertex_t           cnt_q, cnt_d;
  gvc_pkg::vertex_t           cur;
  logic [gvc_pkg::VERTEX_W:0] nxt;
  logic                       wrap;
  logic                       in_xfer;
  gvc_pkg::stage_t            s1_q, s1_d;
  logic [CW-1:0]              fwd_color_q;
  logic [CW-1:0]              mem_rdata;
  logic [CW-1:0]              rd_color;
  logic [CW-1:0]              pick_color;
  logic                       push;
  gvc_pkg::result_t           push_data;
  gvc_pkg::result_t           head;
  logic [gvc_pkg::OQ_CW-1:0]  q_count;
  logic [gvc_pkg::OQ_CW:0]    pending;

  assign pending    = {1'b0, q_count} + {{gvc_pkg::OQ_CW{1'b0}}, (s1_q.valid && s1_q.last)};
  assign in_ready_o = (pending <= (gvc_pkg::OQ_CW + 1)'(gvc_pkg::OQ_DEPTH - 1));
  assign in_xfer    = in_valid_i && in_ready_o;

  assign cur  = first_vertex_i ? '0 : cnt_q;
  assign nxt  = {1'b0, cur} + 1'b1;
  assign wrap = nxt[gvc_pkg::VERTEX_W] || (32'(nxt) >= MAX_VERTICES);

  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer) begin
      if (last_i) begin
        cnt_d = wrap ? '0 : nxt[gvc_pkg::VERTEX_W-1:0];
      end else begin
        cnt_d = cur;
      end
    end
    s1_d.valid  = in_xfer;
    s1_d.hit    = neighbor_valid_i && (neighbor_i < cur);
    s1_d.last   = last_i;
    s1_d.vertex = cur;
    s1_d.fwd    = push && (neighbor_i == s1_q.vertex);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      s1_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      s1_q  <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_color_q <= pick_color;
  end

  assign rd_color = s1_q.fwd ? fwd_color_q : mem_rdata;

  gvc_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (CW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (s1_q.vertex[AW-1:0]),
    .wdata_i (pick_color),
    .re_i    (in_xfer),
    .raddr_i (neighbor_i[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  gvc_mark #(
    .MAX_COLORS (MAX_COLORS),
    .CW         (CW)
  ) u_mark (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (s1_q),
    .rd_color_i (rd_color),
    .color_o    (pick_color),
    .push_o     (push),
    .result_o   (push_data)
  );

  gvc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (out_ready_i),
    .valid_o (out_valid_o),
    .data_o  (head),
    .count_o (q_count)
  );

  assign vertex_o   = head.vertex;
  assign color_o    = head.color;
  assign overflow_o = head.overflow;

endmodule

// File: hdl/gvc_store.sv
// color store: synchronous memory, one write and one read port
module gvc_store #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16,
  parameter int unsigned DW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/gvc_mark.sv
// used-color mask and lowest free color pick
module gvc_mark #(
  parameter int unsigned MAX_COLORS = 32,
  parameter int unsigned CW         = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gvc_pkg::stage_t  stage_i,
  input  logic [CW-1:0]    rd_color_i,
  output logic [CW-1:0]    color_o,
  output logic             push_o,
  output gvc_pkg::result_t result_o
);

  logic [MAX_COLORS-1:0] used_q;
  logic [MAX_COLORS-1:0] used_d;
  logic [MAX_COLORS-1:0] mark;
  logic [MAX_COLORS-1:0] used_now;
  logic [MAX_COLORS-1:0] free;
  logic [CW-1:0]         pick;
  logic                  done;
  logic [gvc_pkg::COLOR_W+CW-1:0] color_ext;

  assign done     = stage_i.valid && stage_i.last;
  assign mark     = (stage_i.valid && stage_i.hit) ?
                    (MAX_COLORS'(1) << rd_color_i) : '0;
  assign used_now = used_q | mark;
  assign free     = ~used_now;

  always_comb begin
    pick = CW'(MAX_COLORS - 1);
    for (int i = MAX_COLORS - 1; i >= 0; i--) begin
      if (free[i]) begin
        pick = CW'(i);
      end
    end
  end

  assign used_d = done ? '0 : used_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  assign color_ext         = {{gvc_pkg::COLOR_W{1'b0}}, pick};
  assign color_o           = pick;
  assign push_o            = done;
  assign result_o.vertex   = stage_i.vertex;
  assign result_o.color    = color_ext[gvc_pkg::COLOR_W-1:0];
  assign result_o.overflow = &used_now;

endmodule

// File: hdl/gvc_outq.sv
// three-entry result queue in front of the output channel
module gvc_outq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  gvc_pkg::result_t             data_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output gvc_pkg::result_t             data_o,
  output logic [gvc_pkg::OQ_CW-1:0]    count_o
);

  gvc_pkg::result_t             buf_q [gvc_pkg::OQ_DEPTH];
  logic [gvc_pkg::OQ_PW-1:0]    wptr_q, wptr_d;
  logic [gvc_pkg::OQ_PW-1:0]    rptr_q, rptr_d;
  logic [gvc_pkg::OQ_CW-1:0]    cnt_q, cnt_d;
  logic                         do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == gvc_pkg::OQ_PW'(gvc_pkg::OQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == gvc_pkg::OQ_PW'(gvc_pkg::OQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rptr_q];
  assign count_o = cnt_q;

endmodule

// File: hdl/gvc_check.sv
// port-level checks for the greedy vertex coloring block, with bind
module gvc_check #(
  parameter int unsigned MAX_COLORS = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] vertex_o,
  input logic [4:0]  color_o,
  input logic        overflow_o
);

  localparam logic [4:0] TOP_COLOR = 5'(MAX_COLORS - 1);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(vertex_o) && $stable(color_o) && $stable(overflow_o))
    else $error("stalled result changed");

  a_overflow_color : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> color_o == TOP_COLOR)
    else $error("overflow without saturated color");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_last_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i |-> ##2 out_valid_o)
    else $error("last transfer gave no result");

endmodule

bind greedy_vertex_coloring gvc_check #(.MAX_COLORS(MAX_COLORS)) u_check (.*);
